// ===== design/mawc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mawc_pkg;

    localparam int ADDR_BYTES_DEF = 6;
    localparam int COMBOS_DEF     = 8;
    localparam int OUT_BYTES      = 6;
    localparam int OUT_ADDR_W     = OUT_BYTES * 8;
    localparam int CFG_DATA_W     = 32;
    localparam int CFG_ADDR_W     = 3;
    localparam int COMBO_IDX_W    = 3;

    localparam logic [7:0] WILDCARD   = 8'hAA;
    localparam logic [7:0] LAST_DIGIT = 8'h99;
    localparam logic [3:0] NIBBLE_MAX = 4'd9;
    localparam logic [5:0] BAUD_BASE  = 6'd4;

    // request codes
    localparam logic REQ_START  = 1'b0;
    localparam logic REQ_REPORT = 1'b1;

    // probe outcome codes
    localparam logic [1:0] ACK_NONE  = 2'd0;
    localparam logic [1:0] ACK_ONE   = 2'd1;
    localparam logic [1:0] ACK_MIXED = 2'd2;
    localparam logic [1:0] ACK_RSVD  = 2'd3;

    // register word index
    localparam logic REG_COMBO_ENABLE = 1'b0;

    typedef struct packed {
        logic       req_type;
        logic [1:0] ack_kind;
    } t_in_beat;

    typedef struct packed {
        logic [OUT_ADDR_W-1:0] probe_address;
        logic                  protocol_is_2007;
        logic [5:0]            baud_divisor;
        logic                  search_done;
    } t_out_beat;

    typedef struct packed {
        logic [8:0] sum;
        logic       op_below;
        logic       sum_below;
    } t_bcd_res;

endpackage

`default_nettype wire

// ===== design/mawc_bcd_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mawc_bcd_unit
    import mawc_pkg::*;
(
    input  wire logic [7:0] i_operand,
    output t_bcd_res        o_res
);

    logic [3:0] lo;
    logic [3:0] hi;
    logic [8:0] sum;

    assign lo = i_operand[3:0];
    assign hi = i_operand[7:4];

    // low digit wraps at nine, upper nibble may grow past 9 (non-bcd input)
    always_comb begin
        if (lo >= NIBBLE_MAX) begin
            sum = {({1'b0, hi} + 5'd1), 4'h0};
        end else begin
            sum = {1'b0, hi, lo + 4'd1};
        end
    end

    assign o_res.sum       = sum;
    assign o_res.op_below  = (i_operand < LAST_DIGIT);
    assign o_res.sum_below = (sum < {1'b0, LAST_DIGIT});

endmodule

`default_nettype wire

// ===== design/mawc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mawc_ctrl
    import mawc_pkg::*;
#(
    parameter int ADDR_BYTES = ADDR_BYTES_DEF,
    parameter int COMBOS     = COMBOS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire t_in_beat   i_in,
    input  wire logic [7:0] i_combo_enable,
    input  wire logic       i_res_take,
    output logic            o_idle,
    output logic            o_res_valid,
    output t_out_beat       o_res
);

    localparam int LW = $clog2(ADDR_BYTES);
    localparam logic [LW-1:0] LVL_MAX = LW'(ADDR_BYTES - 1);
    localparam logic [LW-1:0] LVL_ONE = LW'(1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EVAL   = 5'b00010,
        S_WALK   = 5'b00100,
        S_NEXT   = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    t_state                 r_state, n_state;
    logic                   r_req, n_req;
    logic [1:0]             r_ack, n_ack;
    logic [COMBOS-1:0]      r_remaining, n_remaining;
    logic [COMBO_IDX_W-1:0] r_combo, n_combo;
    logic [7:0]             r_addr [ADDR_BYTES];
    logic [7:0]             n_addr [ADDR_BYTES];
    logic [LW-1:0]          r_level, n_level;
    logic [7:0]             r_digit, n_digit;
    logic                   r_narrow, n_narrow;

    logic [COMBOS-1:0]      combo_bit;
    logic                   found;
    logic [COMBO_IDX_W-1:0] first;
    logic [LW-1:0]          lvl_up;
    logic [7:0]             bcd_op;
    t_bcd_res               bcd;
    logic [OUT_ADDR_W-1:0]  addr_flat;

    mawc_bcd_unit u_bcd (
        .i_operand (bcd_op),
        .o_res     (bcd)
    );

    // shared incrementer: current digit on a report, earlier byte while backing up
    assign bcd_op = (r_state == S_WALK) ? r_addr[r_level] : r_digit;

    assign combo_bit = {{(COMBOS-1){1'b0}}, 1'b1} << r_combo;

    // lowest remaining combination
    always_comb begin
        found = 1'b0;
        first = '0;
        for (int k = COMBOS - 1; k >= 0; k--) begin
            if (r_remaining[k]) begin
                found = 1'b1;
                first = COMBO_IDX_W'(k);
            end
        end
    end

    assign lvl_up = (r_narrow && (r_level < LVL_MAX)) ? r_level + LVL_ONE : r_level;

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_ack       = r_ack;
        n_remaining = r_remaining;
        n_combo     = r_combo;
        n_addr      = r_addr;
        n_level     = r_level;
        n_digit     = r_digit;
        n_narrow    = r_narrow;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req   = i_in.req_type;
                    n_ack   = i_in.ack_kind;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_RESULT;
                if (r_req == REQ_START) begin
                    n_remaining = i_combo_enable[COMBOS-1:0];
                    n_state     = S_NEXT;
                end else if ((r_remaining != '0) && (r_ack != ACK_RSVD)) begin
                    if (r_ack == ACK_MIXED) begin
                        // collision: fix the next byte at 00
                        n_level         = lvl_up;
                        n_digit         = 8'h00;
                        n_addr[lvl_up]  = 8'h00;
                        n_narrow        = 1'b1;
                    end else if (!r_narrow) begin
                        // answer on the all-wildcard probe ends this combination
                        n_remaining = r_remaining & ~combo_bit;
                        n_state     = S_NEXT;
                    end else if (bcd.op_below) begin
                        n_digit          = bcd.sum[7:0];
                        n_addr[r_level]  = bcd.sum[7:0];
                    end else if (r_level == '0) begin
                        n_remaining = r_remaining & ~combo_bit;
                        n_narrow    = 1'b0;
                        n_state     = S_NEXT;
                    end else begin
                        n_level = r_level - LVL_ONE;
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                // back up one byte a cycle until an increment stays below 99
                n_digit = bcd.sum[7:0];
                if (bcd.sum_below) begin
                    if (r_level < LVL_MAX) begin
                        n_addr[r_level + LVL_ONE] = WILDCARD;
                    end
                    n_addr[r_level] = bcd.sum[7:0];
                    n_state         = S_RESULT;
                end else if (r_level == '0) begin
                    n_remaining = r_remaining & ~combo_bit;
                    n_narrow    = 1'b0;
                    n_state     = S_NEXT;
                end else begin
                    n_level = r_level - LVL_ONE;
                end
            end
            S_NEXT: begin
                if (found) begin
                    n_combo  = first;
                    n_narrow = 1'b0;
                    n_digit  = 8'h00;
                    n_level  = '0;
                    for (int i = 0; i < ADDR_BYTES; i++) begin
                        n_addr[i] = WILDCARD;
                    end
                end else begin
                    n_remaining = '0;
                end
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_remaining <= '0;
            r_combo     <= '0;
            r_level     <= '0;
            r_digit     <= 8'h00;
            r_narrow    <= 1'b0;
            for (int i = 0; i < ADDR_BYTES; i++) begin
                r_addr[i] <= WILDCARD;
            end
        end else begin
            r_state     <= n_state;
            r_remaining <= n_remaining;
            r_combo     <= n_combo;
            r_level     <= n_level;
            r_digit     <= n_digit;
            r_narrow    <= n_narrow;
            r_addr      <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_ack <= n_ack;
    end

    for (genvar j = 0; j < OUT_BYTES; j++) begin : g_out_byte
        if (j < ADDR_BYTES) begin : g_used
            assign addr_flat[j*8 +: 8] = r_addr[j];
        end else begin : g_pad
            assign addr_flat[j*8 +: 8] = 8'h00;
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESULT);

    always_comb begin
        if (r_remaining == '0) begin
            o_res.probe_address    = '0;
            o_res.protocol_is_2007 = 1'b0;
            o_res.baud_divisor     = '0;
            o_res.search_done      = 1'b1;
        end else begin
            o_res.probe_address    = addr_flat;
            o_res.protocol_is_2007 = r_combo[0];
            o_res.baud_divisor     = BAUD_BASE << r_combo[2:1];
            o_res.search_done      = 1'b0;
        end
    end

`ifndef SYNTH
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LVL_MAX)
        else $error("level index beyond address bytes");

    a_walk_narrowed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> r_narrow)
        else $error("backtrack without narrowing");

    a_combo_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RESULT) && (r_remaining != '0)) |-> ((r_remaining & combo_bit) != '0))
        else $error("current combination not among remaining ones");

    a_start_probes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EVAL) && (r_req == REQ_START) && (i_combo_enable[COMBOS-1:0] != '0))
        |-> ##2 ((r_state == S_RESULT) && !o_res.search_done))
        else $error("start with enabled combinations gave no probe");
`endif

endmodule

`default_nettype wire

// ===== design/meter_address_wildcard_search.sv =====
// Wildcard meter address search: hands out the next address to probe.
// Input channel (i_in_valid / o_in_ready / i_in_data): one beat is either a start
// request or the outcome of the last probe (no reply, one reply, collision).
// Output channel (o_out_valid / i_out_ready / o_out_data): exactly one beat per
// input beat, carrying the probe address, frame type and baud divisor, or
// search_done once every enabled protocol/baud combination is exhausted.
// APB port: register 0 at byte address 0 holds the 8-bit combination enable
// mask (reset 0xFF); write it only while no beat is in flight.
// Steps: the input beat is evaluated and its result goes to the output register;
// a combination is picked in a further state (on a start or when the
// current one ends), and the search backs up through earlier address bytes,
// one byte a cycle through the shared bcd incrementer.
// One input beat is taken at a time.
// The output beat sits in a register: the next input beat is accepted while it
// waits, and that beat's result is held back until the register is taken.
// Reset: no search active, so a report before any start returns search_done.
`timescale 1ns / 1ps
`default_nettype none

module meter_address_wildcard_search
    import mawc_pkg::*;
#(
    parameter int ADDR_BYTES = ADDR_BYTES_DEF,
    parameter int COMBOS     = COMBOS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_beat              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_beat                  o_out_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic       sel_combo_enable;
    logic [7:0] r_enable;
    logic       r_out_valid;
    t_out_beat  r_out_data;
    logic       ctrl_idle;
    logic       res_valid;
    logic       res_take;
    t_out_beat  res;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign sel_combo_enable = (paddr[2] == REG_COMBO_ENABLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 8'hFF;
        end else if (cfg_wr && sel_combo_enable) begin
            r_enable <= pwdata[7:0];
        end
    end

    assign prdata = sel_combo_enable ? {{(CFG_DATA_W-8){1'b0}}, r_enable} : '0;

    assign o_in_ready = ctrl_idle;
    assign res_take   = !r_out_valid || i_out_ready;

    mawc_ctrl #(
        .ADDR_BYTES (ADDR_BYTES),
        .COMBOS     (COMBOS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_in_valid && ctrl_idle),
        .i_in           (i_in_data),
        .i_combo_enable (r_enable),
        .i_res_take     (res_take),
        .o_idle         (ctrl_idle),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    // output register parts the search from the receiver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_take) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ===== dv/tb_meter_address_wildcard_search.sv =====
`timescale 1ns / 1ps

module tb_meter_address_wildcard_search
    import mawc_pkg::*;
();

    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = ADDR_BYTES_DEF + 4;

    typedef enum logic [1:0] {
        PROBE_UNSENT,
        PROBE_SILENT,
        PROBE_SINGLE,
        PROBE_COLLIDED
    } t_probe_outcome;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  in_valid;
    logic                  o_in_ready;
    t_in_beat              in_data;
    logic                  o_out_valid;
    logic                  out_ready;
    t_out_beat             o_out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int send_idle_pct;
    int recv_idle_pct;
    int mismatch_count;

    t_out_beat pending_probes[$];

    // search state mirrored by the predictor
    logic [7:0]     enable_mask;
    logic [7:0]     combos_left;
    logic [2:0]     combo_sel;
    logic [7:0]     addr_b [ADDR_BYTES_DEF];
    logic [2:0]     depth;
    logic [7:0]     digit;
    logic           narrowing;
    t_probe_outcome outcome;

    meter_address_wildcard_search u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [8:0] bcd_inc(input logic [7:0] v);
        logic [4:0] hi;
        logic [3:0] lo;
        hi = {1'b0, v[7:4]};
        lo = v[3:0];
        if (lo >= NIBBLE_MAX) begin
            lo = 4'd0;
            hi = hi + 5'd1;
        end else begin
            lo = lo + 4'd1;
        end
        return {hi, lo};
    endfunction

    // lowest remaining combination, fresh wildcard address
    function automatic bit pick_combo();
        for (int k = 0; k < COMBOS_DEF; k++) begin
            if (combos_left[k]) begin
                combo_sel = 3'(k);
                foreach (addr_b[i]) addr_b[i] = WILDCARD;
                narrowing = 1'b0;
                digit     = 8'h00;
                depth     = 3'd0;
                outcome   = PROBE_UNSENT;
                return 1'b1;
            end
        end
        combos_left = '0;
        return 1'b0;
    endfunction

    function automatic bit step_address();
        logic [8:0] nxt;
        if (!narrowing && (outcome == PROBE_SILENT || outcome == PROBE_SINGLE)) begin
            combos_left[combo_sel] = 1'b0;
            return 1'b0;
        end
        if (!narrowing && outcome == PROBE_UNSENT) begin
            foreach (addr_b[i]) addr_b[i] = WILDCARD;
            return 1'b1;
        end
        if (outcome == PROBE_SILENT || outcome == PROBE_SINGLE) begin
            outcome = PROBE_UNSENT;
            if (digit < LAST_DIGIT) begin
                nxt = bcd_inc(digit);
                digit = nxt[7:0];
                addr_b[depth] = digit;
            end else begin
                // back up; an upper byte that would reach 99 is passed over
                while (depth > 3'd0) begin
                    depth = depth - 3'd1;
                    nxt = bcd_inc(addr_b[depth]);
                    digit = nxt[7:0];
                    if (nxt < {1'b0, LAST_DIGIT}) begin
                        if (depth + 1 < ADDR_BYTES_DEF)
                            addr_b[depth + 3'd1] = WILDCARD;
                        addr_b[depth] = nxt[7:0];
                        return 1'b1;
                    end
                end
                combos_left[combo_sel] = 1'b0;
                narrowing = 1'b0;
                return 1'b0;
            end
        end
        if (outcome == PROBE_COLLIDED) begin
            outcome = PROBE_UNSENT;
            if (narrowing && depth + 1 < ADDR_BYTES_DEF)
                depth = depth + 3'd1;
            digit = 8'h00;
            addr_b[depth] = 8'h00;
        end
        narrowing = 1'b1;
        return 1'b1;
    endfunction

    function automatic void advance_search();
        while (!step_address()) begin
            if (!pick_combo())
                break;
        end
    endfunction

    function automatic t_out_beat predict_probe(input t_in_beat beat);
        t_out_beat r;
        if (beat.req_type == REQ_START) begin
            combos_left = enable_mask;
            if (pick_combo())
                advance_search();
        end else if (combos_left != '0 && beat.ack_kind != ACK_RSVD) begin
            case (beat.ack_kind)
                ACK_NONE: outcome = PROBE_SILENT;
                ACK_ONE:  outcome = PROBE_SINGLE;
                default:  outcome = PROBE_COLLIDED;
            endcase
            advance_search();
        end
        r = '0;
        if (combos_left == '0) begin
            r.search_done = 1'b1;
        end else begin
            for (int i = 0; i < OUT_BYTES; i++)
                r.probe_address[8*i +: 8] = addr_b[i];
            r.protocol_is_2007 = combo_sel[0];
            r.baud_divisor     = BAUD_BASE << combo_sel[2:1];
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_beat exp_beat;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_probes.size() == 0) begin
                $error("result beat with nothing pending: %h", o_out_data);
                mismatch_count++;
            end else begin
                exp_beat = pending_probes.pop_front();
                compare_field("probe_address", 64'(exp_beat.probe_address),
                              64'(o_out_data.probe_address));
                compare_field("protocol_is_2007", 64'(exp_beat.protocol_is_2007),
                              64'(o_out_data.protocol_is_2007));
                compare_field("baud_divisor", 64'(exp_beat.baud_divisor),
                              64'(o_out_data.baud_divisor));
                compare_field("search_done", 64'(exp_beat.search_done),
                              64'(o_out_data.search_done));
            end
        end
    end

    task automatic send_beat(input logic req, input logic [1:0] ack);
        t_in_beat beat;
        beat.req_type = req;
        beat.ack_kind = ack;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        pending_probes.push_back(predict_probe(beat));
    endtask

    task automatic send_reports(input logic [1:0] ack, input int count);
        repeat (count) send_beat(REQ_REPORT, ack);
    endtask

    task automatic wait_drained();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        while (pending_probes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write the enable mask, then read it back
    task automatic program_combos(input logic [7:0] mask);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_COMBO_ENABLE, 2'b00};
        pwdata  <= {{(CFG_DATA_W-8){1'b0}}, mask};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        enable_mask = mask;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata[7:0] !== mask) begin
            $error("combo_enable readback: expected %0h, got %0h", mask, prdata[7:0]);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_report_before_start();
        send_beat(REQ_REPORT, ACK_NONE);
        send_beat(REQ_REPORT, ACK_MIXED);
    endtask

    // no reply or one reply on the all-wildcard probe ends that combination
    task automatic test_wildcard_replies();
        send_beat(REQ_START, ACK_NONE);
        send_beat(REQ_REPORT, ACK_NONE);
        send_beat(REQ_REPORT, ACK_ONE);
        send_beat(REQ_REPORT, ACK_RSVD);
    endtask

    // narrow through every byte, then collide again on the last one
    task automatic test_collision_depth();
        send_reports(ACK_MIXED, ADDR_BYTES_DEF + 1);
        send_beat(REQ_REPORT, ACK_ONE);
        send_beat(REQ_REPORT, ACK_NONE);
    endtask

    task automatic test_restart();
        send_beat(REQ_START, ACK_RSVD);
        send_beat(REQ_REPORT, ACK_MIXED);
        send_beat(REQ_START, ACK_MIXED);
    endtask

    task automatic test_config_extremes();
        wait_drained();
        program_combos(8'h00);
        send_beat(REQ_START, ACK_ONE);
        send_beat(REQ_REPORT, ACK_ONE);
        wait_drained();
        program_combos(8'h80);
        send_beat(REQ_START, ACK_NONE);
        send_beat(REQ_REPORT, ACK_NONE);
    endtask

    task automatic test_digit_rollover();
        // back up from byte 1 into byte 0, then run byte 0 out
        wait_drained();
        program_combos(8'h80);
        send_beat(REQ_START, ACK_NONE);
        send_reports(ACK_MIXED, 2);
        send_reports(ACK_NONE, 100);
        send_reports(ACK_NONE, 99);
        // byte 0 at 98 would step to 99 on the way back, so the search ends
        wait_drained();
        program_combos(8'h04);
        send_beat(REQ_START, ACK_ONE);
        send_beat(REQ_REPORT, ACK_MIXED);
        send_reports(ACK_ONE, 98);
        send_beat(REQ_REPORT, ACK_MIXED);
        send_reports(ACK_NONE, 100);
        send_beat(REQ_REPORT, ACK_NONE);
        wait_drained();
        program_combos(8'hFF);
    endtask

    task automatic test_random_search(input int target);
        int         counted;
        int         span;
        int         collide_pct;
        int         pct;
        int         roll;
        logic       req;
        logic [1:0] ack;
        logic [7:0] mask;
        counted = 0;
        while (counted < target) begin
            if ($urandom_range(9) < 3) begin
                wait_drained();
                case ($urandom_range(7))
                    0, 1, 2: mask = 8'hFF;
                    3, 4:    mask = 8'h01 << $urandom_range(7);
                    5, 6:    mask = 8'($urandom_range(255));
                    default: mask = 8'h00;
                endcase
                program_combos(mask);
            end
            send_beat(REQ_START, 2'($urandom_range(3)));
            counted++;
            span        = $urandom_range(250, 10);
            collide_pct = $urandom_range(25, 2);
            for (int n = 0; n < span; n++) begin
                if (combos_left == '0 && $urandom_range(3) != 0)
                    break;
                // mostly collide on the wildcard probe so the search gets going
                pct  = narrowing ? collide_pct : 70;
                roll = $urandom_range(99);
                req  = REQ_REPORT;
                if (roll < 3) begin
                    req = REQ_START;
                    ack = 2'($urandom_range(3));
                end else if (roll < 6) begin
                    ack = ACK_RSVD;
                end else if (roll < 6 + pct) begin
                    ack = ACK_MIXED;
                end else if (roll < 16 + pct) begin
                    ack = ACK_ONE;
                end else begin
                    ack = ACK_NONE;
                end
                if (!(req == REQ_REPORT && (combos_left == '0 || ack == ACK_RSVD)))
                    counted++;
                send_beat(req, ack);
            end
        end
    endtask

    initial begin
        i_rst_n   <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        mismatch_count = 0;
        enable_mask    = 8'hFF;
        combos_left    = '0;
        combo_sel      = 3'd0;
        foreach (addr_b[i]) addr_b[i] = WILDCARD;
        depth          = 3'd0;
        digit          = 8'h00;
        narrowing      = 1'b0;
        outcome        = PROBE_UNSENT;
        send_idle_pct  = 32;
        recv_idle_pct  = 86;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_report_before_start();
        test_wildcard_replies();
        test_collision_depth();
        test_restart();
        test_config_extremes();
        test_digit_rollover();
        test_random_search(430);
        send_idle_pct = 86;
        recv_idle_pct = 32;
        test_random_search(430);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_search(430);

        wait_drained();
        if (pending_probes.size() != 0) begin
            $error("%0d result beats never arrived", pending_probes.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
